// ----- design/tlvrpe_pkg.sv -----
// Shared types and constants for the TLV route path extractor.
// No dependencies; the controller, datapath and core take names from here.
package tlvrpe_pkg;

   localparam int BYTE_W     = 8;
   localparam int ID_W       = 64;
   localparam int ID_BYTES   = 8;
   localparam int BYTE_SHIFT = 3;
   localparam int CNT_W      = 4;
   localparam int LEN_W      = 8;

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LEN,
      PH_VALUE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_MALFORMED,
      ST_NOT_FOUND
   } status_type;

   typedef enum logic [2:0] {
      CS_PARSE,
      CS_JUDGE,
      CS_CHK_RD,
      CS_CHK_CMP,
      CS_EMIT_RD,
      CS_EMIT_OUT,
      CS_FAIL
   } ctl_state_type;

   typedef struct packed {
      logic       take;
      logic       idx_clear;
      logic       chk_rd;
      logic       chk_adv;
      logic       emit_rd;
      logic       emit_load;
      logic       fail_load;
      status_type fail_status;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic error_seen;
      logic path_found;
      logic length_ok;
      logic chk_fail;
      logic idx_last;
      logic out_free;
   } sts_type;

endpackage

// ----- design/tlvrpe_req_if.sv -----
// Input channel: one payload byte per item, last byte marked.
// Depends on nothing.
interface tlvrpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;

   modport source (output valid, output payload_byte, output last_byte, input ready);
   modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

// ----- design/tlvrpe_rsp_if.sv -----
// Result channel: status, node id, index, count and last marker per item.
// Depends on nothing.
interface tlvrpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] node_id;
   logic [3:0]  node_index;
   logic [3:0]  node_count;
   logic        last_result;

   modport source (output valid, output status, output node_id, output node_index,
                   output node_count, output last_result, input ready);
   modport sink (input valid, input status, input node_id, input node_index,
                 input node_count, input last_result, output ready);
endinterface

// ----- design/tlv_route_path_extractor_core.sv -----
// TLV route path extractor: one payload byte per cycle while parsing.
// After the last byte: a judge state, then a read and a compare state per id pair
// checked (n*(n+1)/2 pairs for n nodes), then a read and an output state per emitted
// node; an error gives one result after the judge or the failing compare. Reset
// is synchronous, active high, and clears control and parse state; the node store
// is not cleared.
module tlv_route_path_extractor_core #(
   parameter int MAX_NODES = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   tlvrpe_req_if.sink           req_ch,
   tlvrpe_rsp_if.source         rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);

   tlvrpe_pkg::cmd_type    cmd;
   tlvrpe_pkg::sts_type    sts;
   tlvrpe_pkg::status_type rsp_status;

   tlvrpe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_last_byte (req_ch.last_byte),
      .req_ready     (req_ch.ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   tlvrpe_dpath #(
      .MAX_NODES (MAX_NODES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_payload_byte (req_ch.payload_byte),
      .req_last_byte    (req_ch.last_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_status       (rsp_status),
      .rsp_node_id      (rsp_ch.node_id),
      .rsp_node_index   (rsp_ch.node_index),
      .rsp_node_count   (rsp_ch.node_count),
      .rsp_last_result  (rsp_ch.last_result)
   );

   assign rsp_ch.status = rsp_status;

`ifndef SYNTHESIS
   a_err_single : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_status != tlvrpe_pkg::ST_OK) |->
         rsp_ch.last_result && (rsp_ch.node_count == 4'd0))
      else $error("error result not single");

   a_ok_index : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_status == tlvrpe_pkg::ST_OK) |->
         (rsp_ch.node_index < rsp_ch.node_count))
      else $error("node index out of range");

   a_ok_last : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_status == tlvrpe_pkg::ST_OK) && rsp_ch.last_result |->
         (rsp_ch.node_index + 4'd1 == rsp_ch.node_count))
      else $error("last marker not on final node");

   a_ok_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_status == tlvrpe_pkg::ST_OK) |-> (rsp_ch.node_id != 64'd0))
      else $error("zero id emitted as ok");
`endif

endmodule

// ----- design/tlvrpe_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module tlvrpe_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 9,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- design/tlvrpe_ctrl.sv -----
// Controller: sequences parsing, end-of-payload judgment, id checks and emission.
// Depends on tlvrpe_pkg.
module tlvrpe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_byte,
   output logic                req_ready,
   input  tlvrpe_pkg::sts_type sts,
   output tlvrpe_pkg::cmd_type cmd
);

   tlvrpe_pkg::ctl_state_type state_ff, state_in;
   tlvrpe_pkg::status_type    fail_code_ff, fail_code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlvrpe_pkg::CS_PARSE;
         fail_code_ff <= tlvrpe_pkg::ST_MALFORMED;
      end else begin
         state_ff     <= state_in;
         fail_code_ff <= fail_code_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      fail_code_in    = fail_code_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.fail_status = fail_code_ff;
      unique case (state_ff)
         tlvrpe_pkg::CS_PARSE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_last_byte) begin
                  state_in = tlvrpe_pkg::CS_JUDGE;
               end
            end
         end
         tlvrpe_pkg::CS_JUDGE: begin
            if (sts.error_seen) begin
               fail_code_in = tlvrpe_pkg::ST_MALFORMED;
               state_in     = tlvrpe_pkg::CS_FAIL;
            end else if (!sts.path_found) begin
               fail_code_in = tlvrpe_pkg::ST_NOT_FOUND;
               state_in     = tlvrpe_pkg::CS_FAIL;
            end else if (!sts.length_ok) begin
               fail_code_in = tlvrpe_pkg::ST_MALFORMED;
               state_in     = tlvrpe_pkg::CS_FAIL;
            end else begin
               cmd.idx_clear = 1'b1;
               state_in      = tlvrpe_pkg::CS_CHK_RD;
            end
         end
         tlvrpe_pkg::CS_CHK_RD: begin
            cmd.chk_rd = 1'b1;
            state_in   = tlvrpe_pkg::CS_CHK_CMP;
         end
         tlvrpe_pkg::CS_CHK_CMP: begin
            if (sts.chk_fail) begin
               fail_code_in = tlvrpe_pkg::ST_MALFORMED;
               state_in     = tlvrpe_pkg::CS_FAIL;
            end else if (sts.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = tlvrpe_pkg::CS_EMIT_RD;
            end else begin
               cmd.chk_adv = 1'b1;
               state_in    = tlvrpe_pkg::CS_CHK_RD;
            end
         end
         tlvrpe_pkg::CS_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = tlvrpe_pkg::CS_EMIT_OUT;
         end
         tlvrpe_pkg::CS_EMIT_OUT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.idx_last) begin
                  cmd.clear = 1'b1;
                  state_in  = tlvrpe_pkg::CS_PARSE;
               end else begin
                  state_in = tlvrpe_pkg::CS_EMIT_RD;
               end
            end
         end
         tlvrpe_pkg::CS_FAIL: begin
            if (sts.out_free) begin
               cmd.fail_load = 1'b1;
               cmd.clear     = 1'b1;
               state_in      = tlvrpe_pkg::CS_PARSE;
            end
         end
         default: begin
            state_in = tlvrpe_pkg::CS_PARSE;
         end
      endcase
   end

endmodule

// ----- design/tlvrpe_dpath.sv -----
// Datapath: record walker, node id store, pairwise id checker and result register.
// Depends on tlvrpe_pkg and tlvrpe_ram.
module tlvrpe_dpath #(
   parameter int MAX_NODES = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tlvrpe_pkg::cmd_type               cmd,
   output tlvrpe_pkg::sts_type               sts,
   input  logic [tlvrpe_pkg::BYTE_W-1:0]     req_payload_byte,
   input  logic                              req_last_byte,
   input  logic                              csr_wr_en,
   input  logic [tlvrpe_pkg::BYTE_W-1:0]     csr_wr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output tlvrpe_pkg::status_type            rsp_status,
   output logic [tlvrpe_pkg::ID_W-1:0]       rsp_node_id,
   output logic [tlvrpe_pkg::CNT_W-1:0]      rsp_node_index,
   output logic [tlvrpe_pkg::CNT_W-1:0]      rsp_node_count,
   output logic                              rsp_last_result
);

   localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic [tlvrpe_pkg::LEN_W-1:0] MAX_LEN =
      tlvrpe_pkg::LEN_W'(MAX_NODES * tlvrpe_pkg::ID_BYTES);

   localparam int BW = tlvrpe_pkg::BYTE_W;
   localparam int LW = tlvrpe_pkg::LEN_W;
   localparam int CW = tlvrpe_pkg::CNT_W;
   localparam int IW = tlvrpe_pkg::ID_W;

   logic [BW-1:0]          cfg_type_ff;
   tlvrpe_pkg::phase_type  phase_ff, phase_in;
   logic [BW-1:0]          record_type_ff, record_type_in;
   logic [LW-1:0]          bytes_left_ff, bytes_left_in;
   logic                   path_found_ff, path_found_in;
   logic [LW-1:0]          path_length_ff, path_length_in;
   logic [LW-1:0]          value_pos_ff, value_pos_in;
   logic                   error_seen_ff, error_seen_in;
   logic                   capturing_ff, capturing_in;
   logic [IW-1:0]          word_ff, word_in;
   logic [ADDR_W-1:0]      idx_i_ff, idx_i_in;
   logic [ADDR_W-1:0]      idx_j_ff, idx_j_in;

   logic                   rsp_valid_ff;
   tlvrpe_pkg::status_type rsp_status_ff;
   logic [IW-1:0]          rsp_node_id_ff;
   logic [CW-1:0]          rsp_node_index_ff;
   logic [CW-1:0]          rsp_node_count_ff;
   logic                   rsp_last_ff;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [IW-1:0]          wr_data;
   logic [IW-1:0]          rd_a;
   logic [IW-1:0]          rd_b;
   logic [CW-1:0]          node_cnt;
   logic [CW-1:0]          cnt_last;
   logic                   out_free;
   logic [LW-1:0]          left_dec;

   tlvrpe_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_NODES)
   ) u_node_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (cmd.chk_rd | cmd.emit_rd),
      .rd_addr_a (idx_i_ff),
      .rd_addr_b (idx_j_ff),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign node_cnt = CW'(path_length_ff >> tlvrpe_pkg::BYTE_SHIFT);
   assign cnt_last = node_cnt - CW'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign left_dec = bytes_left_ff - LW'(1);
   assign wr_addr  = ADDR_W'(value_pos_ff >> tlvrpe_pkg::BYTE_SHIFT);
   assign wr_data  = {req_payload_byte, word_ff[IW-1:BW]};

   assign sts.error_seen = error_seen_ff;
   assign sts.path_found = path_found_ff;
   assign sts.length_ok  = (path_length_ff != '0) && (path_length_ff <= MAX_LEN) &&
                           (path_length_ff[tlvrpe_pkg::BYTE_SHIFT-1:0] == '0);
   assign sts.chk_fail   = (idx_i_ff == idx_j_ff) ? (rd_a == '0) : (rd_a == rd_b);
   assign sts.idx_last   = (CW'(idx_i_ff) == cnt_last);
   assign sts.out_free   = out_free;

   // clear the walker state, or walk one byte of the record stream
   always_comb begin
      phase_in       = phase_ff;
      record_type_in = record_type_ff;
      bytes_left_in  = bytes_left_ff;
      path_found_in  = path_found_ff;
      path_length_in = path_length_ff;
      value_pos_in   = value_pos_ff;
      error_seen_in  = error_seen_ff;
      capturing_in   = capturing_ff;
      word_in        = word_ff;
      wr_en          = 1'b0;
      if (cmd.clear) begin
         phase_in       = tlvrpe_pkg::PH_TYPE;
         record_type_in = '0;
         bytes_left_in  = '0;
         path_found_in  = 1'b0;
         path_length_in = '0;
         value_pos_in   = '0;
         error_seen_in  = 1'b0;
         capturing_in   = 1'b0;
      end else if (cmd.take) begin
         if (!error_seen_ff) begin
            unique case (phase_ff)
               tlvrpe_pkg::PH_LEN: begin
                  bytes_left_in = req_payload_byte;
                  capturing_in  = 1'b0;
                  if ((record_type_ff == cfg_type_ff) && path_found_ff) begin
                     error_seen_in = 1'b1;
                  end else begin
                     if (record_type_ff == cfg_type_ff) begin
                        path_found_in  = 1'b1;
                        path_length_in = req_payload_byte;
                        value_pos_in   = '0;
                        capturing_in   = 1'b1;
                     end
                     phase_in = (req_payload_byte == '0) ? tlvrpe_pkg::PH_TYPE
                                                          : tlvrpe_pkg::PH_VALUE;
                  end
               end
               tlvrpe_pkg::PH_VALUE: begin
                  if (capturing_ff) begin
                     word_in      = wr_data;
                     value_pos_in = value_pos_ff + LW'(1);
                     wr_en        = (value_pos_ff < MAX_LEN) &&
                                    (value_pos_ff[tlvrpe_pkg::BYTE_SHIFT-1:0] == '1);
                  end
                  bytes_left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in     = tlvrpe_pkg::PH_TYPE;
                     capturing_in = 1'b0;
                  end
               end
               default: begin
                  record_type_in = req_payload_byte;
                  phase_in       = tlvrpe_pkg::PH_LEN;
               end
            endcase
         end
         if (req_last_byte && (phase_in != tlvrpe_pkg::PH_TYPE)) begin
            error_seen_in = 1'b1;
         end
      end
   end

   // pair and emit indexes
   always_comb begin
      idx_i_in = idx_i_ff;
      idx_j_in = idx_j_ff;
      if (cmd.idx_clear) begin
         idx_i_in = '0;
         idx_j_in = '0;
      end else if (cmd.chk_adv) begin
         if (CW'(idx_j_ff) == cnt_last) begin
            idx_i_in = idx_i_ff + ADDR_W'(1);
            idx_j_in = idx_i_ff + ADDR_W'(1);
         end else begin
            idx_j_in = idx_j_ff + ADDR_W'(1);
         end
      end else if (cmd.emit_load && !sts.idx_last) begin
         idx_i_in = idx_i_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_type_ff    <= '0;
         phase_ff       <= tlvrpe_pkg::PH_TYPE;
         record_type_ff <= '0;
         bytes_left_ff  <= '0;
         path_found_ff  <= 1'b0;
         path_length_ff <= '0;
         value_pos_ff   <= '0;
         error_seen_ff  <= 1'b0;
         capturing_ff   <= 1'b0;
         idx_i_ff       <= '0;
         idx_j_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_type_ff <= csr_wr_data;
         end
         phase_ff       <= phase_in;
         record_type_ff <= record_type_in;
         bytes_left_ff  <= bytes_left_in;
         path_found_ff  <= path_found_in;
         path_length_ff <= path_length_in;
         value_pos_ff   <= value_pos_in;
         error_seen_ff  <= error_seen_in;
         capturing_ff   <= capturing_in;
         idx_i_ff       <= idx_i_in;
         idx_j_ff       <= idx_j_in;
         if (cmd.emit_load || cmd.fail_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (cmd.emit_load) begin
         rsp_status_ff     <= tlvrpe_pkg::ST_OK;
         rsp_node_id_ff    <= rd_a;
         rsp_node_index_ff <= CW'(idx_i_ff);
         rsp_node_count_ff <= node_cnt;
         rsp_last_ff       <= sts.idx_last;
      end else if (cmd.fail_load) begin
         rsp_status_ff     <= cmd.fail_status;
         rsp_node_id_ff    <= '0;
         rsp_node_index_ff <= '0;
         rsp_node_count_ff <= '0;
         rsp_last_ff       <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_node_id     = rsp_node_id_ff;
   assign rsp_node_index  = rsp_node_index_ff;
   assign rsp_node_count  = rsp_node_count_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
